[hw/rtl/alu8_pkg.sv]
// Shared types, operation codes and constants for the 8-bit flag ALU.
package alu8_pkg;

    localparam int unsigned BCD_MAX    = 99;
    localparam int unsigned BCD_MOD    = 100;
    localparam int unsigned BCD_RADIX  = 10;
    localparam int unsigned TENS_RECIP = 205;   // floor(x*205/2048) == x/10 for x < 100
    localparam int unsigned TENS_SHIFT = 11;

    typedef enum logic [3:0] {
        FUNC_ADC     = 4'd0,
        FUNC_AND     = 4'd1,
        FUNC_EOR     = 4'd2,
        FUNC_ORA     = 4'd3,
        FUNC_CMP     = 4'd4,
        FUNC_BIT     = 4'd5,
        FUNC_BIT_IMM = 4'd6,
        FUNC_ASL     = 4'd7,
        FUNC_LSR     = 4'd8,
        FUNC_ROL     = 4'd9,
        FUNC_ROR     = 4'd10,
        FUNC_DEC     = 4'd11,
        FUNC_PASS    = 4'd12
    } t_func;

    typedef struct packed {
        logic [3:0] func;
        logic [7:0] acc;
        logic [7:0] operand;
        logic       carry_in;
        logic       overflow_in;
        logic       negative_in;
        logic       decimal_mode;
    } t_alu_in;

    typedef struct packed {
        logic [7:0] result;
        logic       negative;
        logic       overflow;
        logic       zero;
        logic       carry;
    } t_alu_out;

endpackage

[hw/rtl/alu8_flags_bcd_add_core.sv]
// 8-bit ALU with N/V/Z/C flags and packed BCD add: input register, ALU, result register.
// Each item passes through two registers: it is captured in the input register when it is
// accepted, and its ALU result is captured in the result register when that register can
// take it, so the result is registered and the block takes one item every cycle unless the
// output stalls. The result register is refilled in the same cycle it is emptied; while a
// result waits, the input register still takes one more item, and o_in_ready drops only
// when both are full and the output is stalled. Reset clears both valid flags.
module alu8_flags_bcd_add_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  alu8_pkg::t_alu_in   i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output alu8_pkg::t_alu_out  o_out_data
);

    logic               r_s1_valid;
    alu8_pkg::t_alu_in  r_s1;
    logic               r_out_valid;
    alu8_pkg::t_alu_out r_out;
    alu8_pkg::t_alu_out n_out;

    logic       out_ready;
    logic       s1_ready;

    logic [7:0] a;
    logic [7:0] m;
    logic       cin;
    logic [8:0] bin_sum;
    logic [7:0] bin_res;
    logic       sum_ovf;
    logic [7:0] dec_a;
    logic [7:0] dec_m;
    logic [8:0] dec_sum;
    logic [6:0] dec_mod;
    logic [14:0] tens_prod;
    logic [3:0] tens;
    logic [3:0] ones;
    logic [7:0] diff;
    logic [7:0] res;

    assign out_ready  = !r_out_valid || i_out_ready;
    assign s1_ready   = !r_s1_valid || out_ready;
    assign o_in_ready = s1_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign a   = r_s1.acc;
    assign m   = r_s1.operand;
    assign cin = r_s1.carry_in;

    // binary add and signed overflow
    assign bin_sum = {1'b0, a} + {1'b0, m} + {8'd0, cin};
    assign bin_res = bin_sum[7:0];
    assign sum_ovf = (a[7] ^ bin_res[7]) & (m[7] ^ bin_res[7]);

    // decimal add: weight nibbles, reduce mod 100, re-encode
    assign dec_a   = {1'b0, a[7:4], 3'b000} + {3'b000, a[7:4], 1'b0} + {4'd0, a[3:0]};
    assign dec_m   = {1'b0, m[7:4], 3'b000} + {3'b000, m[7:4], 1'b0} + {4'd0, m[3:0]};
    assign dec_sum = {1'b0, dec_a} + {1'b0, dec_m} + {8'd0, cin};

    always_comb begin
        if (dec_sum >= 9'(3 * alu8_pkg::BCD_MOD)) begin
            dec_mod = 7'(dec_sum - 9'(3 * alu8_pkg::BCD_MOD));
        end else if (dec_sum >= 9'(2 * alu8_pkg::BCD_MOD)) begin
            dec_mod = 7'(dec_sum - 9'(2 * alu8_pkg::BCD_MOD));
        end else if (dec_sum >= 9'(alu8_pkg::BCD_MOD)) begin
            dec_mod = 7'(dec_sum - 9'(alu8_pkg::BCD_MOD));
        end else begin
            dec_mod = dec_sum[6:0];
        end
    end

    assign tens_prod = {8'd0, dec_mod} * 15'(alu8_pkg::TENS_RECIP);
    assign tens      = tens_prod[alu8_pkg::TENS_SHIFT +: 4];
    assign ones      = 4'(dec_mod - 7'({3'd0, tens} * 7'(alu8_pkg::BCD_RADIX)));

    assign diff = a - m;

    always_comb begin
        res            = m;
        n_out.result   = m;
        n_out.overflow = r_s1.overflow_in;
        n_out.carry    = cin;
        n_out.negative = m[7];
        n_out.zero     = (m == 8'd0);
        case (alu8_pkg::t_func'(r_s1.func))
            alu8_pkg::FUNC_ADC: begin
                n_out.overflow = sum_ovf;
                if (r_s1.decimal_mode) begin
                    res         = {tens, ones};
                    n_out.carry = (dec_sum > 9'(alu8_pkg::BCD_MAX));
                end else begin
                    res         = bin_res;
                    n_out.carry = bin_sum[8];
                end
            end
            alu8_pkg::FUNC_AND: res = a & m;
            alu8_pkg::FUNC_EOR: res = a ^ m;
            alu8_pkg::FUNC_ORA: res = a | m;
            alu8_pkg::FUNC_ASL: begin
                res         = {m[6:0], 1'b0};
                n_out.carry = m[7];
            end
            alu8_pkg::FUNC_LSR: begin
                res         = {1'b0, m[7:1]};
                n_out.carry = m[0];
            end
            alu8_pkg::FUNC_ROL: begin
                res         = {m[6:0], cin};
                n_out.carry = m[7];
            end
            alu8_pkg::FUNC_ROR: begin
                res         = {cin, m[7:1]};
                n_out.carry = m[0];
            end
            alu8_pkg::FUNC_DEC: res = m - 8'd1;
            default:            res = m;
        endcase

        n_out.result   = res;
        n_out.negative = res[7];
        n_out.zero     = (res == 8'd0);

        case (alu8_pkg::t_func'(r_s1.func))
            alu8_pkg::FUNC_CMP: begin
                n_out.result   = a;
                n_out.negative = diff[7];
                n_out.zero     = (diff == 8'd0);
                n_out.carry    = (a >= m);
            end
            alu8_pkg::FUNC_BIT: begin
                n_out.result   = a;
                n_out.negative = m[7];
                n_out.overflow = m[6];
                n_out.zero     = ((a & m) == 8'd0);
            end
            alu8_pkg::FUNC_BIT_IMM: begin
                n_out.result   = a;
                n_out.negative = r_s1.negative_in;
                n_out.zero     = ((a & m) == 8'd0);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s1_ready) begin
                r_s1_valid <= i_in_valid;
            end
            if (out_ready) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_ready && i_in_valid) begin
            r_s1 <= i_in_data;
        end
        if (out_ready && r_s1_valid) begin
            r_out <= n_out;
        end
    end

endmodule

[hw/rtl/alu8_chk.sv]
// Port-level checker for the 8-bit flag ALU, bound to the top level.
module alu8_chk (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input alu8_pkg::t_alu_in  i_in_data,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input alu8_pkg::t_alu_out o_out_data
);

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid && !i_out_ready)
        else $error("input stalled without output stall");

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(i_in_valid && o_in_ready, 2))
        else $error("result appeared without an accepted item");

endmodule

bind alu8_flags_bcd_add_core alu8_chk u_alu8_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

[tb/tb_alu8_flags_bcd_add_core.sv]
// Self-checking testbench for the 8-bit flag ALU with BCD add: directed table, then random items.
module tb_alu8_flags_bcd_add_core;

    localparam logic [3:0] FUNC_SPARE_A = 4'd13;
    localparam logic [3:0] FUNC_SPARE_B = 4'd14;
    localparam logic [3:0] FUNC_SPARE_C = 4'd15;
    localparam int         NUM_DIRECTED = 24;
    localparam int         ITEMS_PER_PHASE = 450;
    localparam int         CYCLE_LIMIT = 200000;

    typedef struct {
        alu8_pkg::t_alu_in  stim;
        bit                 typed;
        alu8_pkg::t_alu_out want;
    } t_dir_row;

    localparam alu8_pkg::t_alu_out NO_WANT = '0;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               o_in_ready;
    alu8_pkg::t_alu_in  in_data = '0;
    logic               o_out_valid;
    logic               out_ready = 1'b0;
    alu8_pkg::t_alu_out o_out_data;

    alu8_pkg::t_alu_out pending_results[$];
    int       error_count = 0;
    int       cycle_count = 0;
    int       send_idle_pct = 0;
    int       recv_stall_pct = 0;

    // func, acc, operand, carry_in, overflow_in, negative_in, decimal_mode
    // result, negative, overflow, zero, carry
    t_dir_row directed_rows [NUM_DIRECTED] = '{
        '{'{alu8_pkg::FUNC_ADC,     8'hFF, 8'h01, 1'b0, 1'b0, 1'b0, 1'b0}, 1'b1,
          '{8'h00, 1'b0, 1'b0, 1'b1, 1'b1}},
        '{'{alu8_pkg::FUNC_ADC,     8'h7F, 8'h01, 1'b0, 1'b0, 1'b0, 1'b0}, 1'b1,
          '{8'h80, 1'b1, 1'b1, 1'b0, 1'b0}},
        '{'{alu8_pkg::FUNC_ADC,     8'hFF, 8'hFF, 1'b1, 1'b0, 1'b0, 1'b0}, 1'b1,
          '{8'hFF, 1'b1, 1'b0, 1'b0, 1'b1}},
        '{'{alu8_pkg::FUNC_ADC,     8'h99, 8'h01, 1'b0, 1'b0, 1'b0, 1'b1}, 1'b1,
          '{8'h00, 1'b0, 1'b0, 1'b1, 1'b1}},
        '{'{alu8_pkg::FUNC_ADC,     8'hFF, 8'hFF, 1'b1, 1'b0, 1'b0, 1'b1}, 1'b1,
          '{8'h31, 1'b0, 1'b0, 1'b0, 1'b1}},
        '{'{alu8_pkg::FUNC_ADC,     8'h45, 8'h38, 1'b1, 1'b0, 1'b0, 1'b1}, 1'b0, NO_WANT},
        '{'{alu8_pkg::FUNC_ADC,     8'h0A, 8'hA0, 1'b0, 1'b1, 1'b1, 1'b1}, 1'b0, NO_WANT},
        '{'{alu8_pkg::FUNC_AND,     8'hF0, 8'h0F, 1'b1, 1'b1, 1'b0, 1'b0}, 1'b1,
          '{8'h00, 1'b0, 1'b1, 1'b1, 1'b1}},
        '{'{alu8_pkg::FUNC_EOR,     8'hFF, 8'h00, 1'b0, 1'b0, 1'b1, 1'b0}, 1'b0, NO_WANT},
        '{'{alu8_pkg::FUNC_ORA,     8'h00, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0}, 1'b1,
          '{8'h00, 1'b0, 1'b0, 1'b1, 1'b0}},
        '{'{alu8_pkg::FUNC_CMP,     8'h10, 8'h10, 1'b0, 1'b1, 1'b0, 1'b0}, 1'b1,
          '{8'h10, 1'b0, 1'b1, 1'b1, 1'b1}},
        '{'{alu8_pkg::FUNC_CMP,     8'h00, 8'hFF, 1'b1, 1'b0, 1'b0, 1'b1}, 1'b0, NO_WANT},
        '{'{alu8_pkg::FUNC_BIT,     8'h00, 8'hC0, 1'b1, 1'b0, 1'b0, 1'b0}, 1'b1,
          '{8'h00, 1'b1, 1'b1, 1'b1, 1'b1}},
        '{'{alu8_pkg::FUNC_BIT_IMM, 8'hFF, 8'h00, 1'b0, 1'b1, 1'b1, 1'b0}, 1'b1,
          '{8'hFF, 1'b1, 1'b1, 1'b1, 1'b0}},
        '{'{alu8_pkg::FUNC_ASL,     8'h00, 8'h80, 1'b0, 1'b0, 1'b0, 1'b0}, 1'b1,
          '{8'h00, 1'b0, 1'b0, 1'b1, 1'b1}},
        '{'{alu8_pkg::FUNC_LSR,     8'h00, 8'h01, 1'b0, 1'b0, 1'b0, 1'b0}, 1'b1,
          '{8'h00, 1'b0, 1'b0, 1'b1, 1'b1}},
        '{'{alu8_pkg::FUNC_ROL,     8'h00, 8'h80, 1'b1, 1'b0, 1'b0, 1'b0}, 1'b1,
          '{8'h01, 1'b0, 1'b0, 1'b0, 1'b1}},
        '{'{alu8_pkg::FUNC_ROR,     8'h00, 8'h01, 1'b1, 1'b0, 1'b0, 1'b0}, 1'b1,
          '{8'h80, 1'b1, 1'b0, 1'b0, 1'b1}},
        '{'{alu8_pkg::FUNC_DEC,     8'h00, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0}, 1'b1,
          '{8'hFF, 1'b1, 1'b0, 1'b0, 1'b0}},
        '{'{alu8_pkg::FUNC_DEC,     8'hFF, 8'h01, 1'b1, 1'b1, 1'b1, 1'b1}, 1'b0, NO_WANT},
        '{'{alu8_pkg::FUNC_PASS,    8'h12, 8'h80, 1'b0, 1'b1, 1'b0, 1'b0}, 1'b0, NO_WANT},
        '{'{FUNC_SPARE_A,           8'h34, 8'h55, 1'b1, 1'b0, 1'b1, 1'b0}, 1'b0, NO_WANT},
        '{'{FUNC_SPARE_B,           8'hAA, 8'h00, 1'b0, 1'b1, 1'b0, 1'b1}, 1'b0, NO_WANT},
        '{'{FUNC_SPARE_C,           8'h01, 8'hFE, 1'b1, 1'b1, 1'b1, 1'b1}, 1'b0, NO_WANT}
    };

    alu8_flags_bcd_add_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (o_out_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic alu8_pkg::t_alu_out predict_alu_result(input alu8_pkg::t_alu_in it);
        alu8_pkg::t_alu_out o;
        logic [8:0]  bin_sum;
        logic [7:0]  r;
        logic [7:0]  diff;
        logic [7:0]  ovf_bits;
        int unsigned dec_sum;
        bit          nz_from_r;
        o.overflow = it.overflow_in;
        o.carry    = it.carry_in;
        o.negative = 1'b0;
        o.zero     = 1'b0;
        o.result   = it.acc;
        r          = it.operand;
        nz_from_r  = 1'b1;
        case (it.func)
            alu8_pkg::FUNC_ADC: begin
                bin_sum = {1'b0, it.acc} + {1'b0, it.operand} + {8'd0, it.carry_in};
                r = bin_sum[7:0];
                ovf_bits = (it.acc ^ r) & (it.operand ^ r);
                o.overflow = ovf_bits[7];
                if (it.decimal_mode) begin
                    dec_sum = it.acc[7:4] * alu8_pkg::BCD_RADIX + it.acc[3:0]
                            + it.operand[7:4] * alu8_pkg::BCD_RADIX + it.operand[3:0]
                            + it.carry_in;
                    o.carry = dec_sum > alu8_pkg::BCD_MAX;
                    dec_sum = dec_sum % alu8_pkg::BCD_MOD;
                    r = {4'(dec_sum / alu8_pkg::BCD_RADIX), 4'(dec_sum % alu8_pkg::BCD_RADIX)};
                end else begin
                    o.carry = bin_sum[8];
                end
            end
            alu8_pkg::FUNC_AND: r = it.acc & it.operand;
            alu8_pkg::FUNC_EOR: r = it.acc ^ it.operand;
            alu8_pkg::FUNC_ORA: r = it.acc | it.operand;
            alu8_pkg::FUNC_CMP: begin
                diff = it.acc - it.operand;
                o.negative = diff[7];
                o.zero = diff == 8'd0;
                o.carry = it.acc >= it.operand;
                nz_from_r = 1'b0;
            end
            alu8_pkg::FUNC_BIT: begin
                o.negative = it.operand[7];
                o.overflow = it.operand[6];
                o.zero = (it.acc & it.operand) == 8'd0;
                nz_from_r = 1'b0;
            end
            alu8_pkg::FUNC_BIT_IMM: begin
                o.negative = it.negative_in;
                o.zero = (it.acc & it.operand) == 8'd0;
                nz_from_r = 1'b0;
            end
            alu8_pkg::FUNC_ASL: begin
                o.carry = it.operand[7];
                r = {it.operand[6:0], 1'b0};
            end
            alu8_pkg::FUNC_LSR: begin
                o.carry = it.operand[0];
                r = {1'b0, it.operand[7:1]};
            end
            alu8_pkg::FUNC_ROL: begin
                o.carry = it.operand[7];
                r = {it.operand[6:0], it.carry_in};
            end
            alu8_pkg::FUNC_ROR: begin
                o.carry = it.operand[0];
                r = {it.carry_in, it.operand[7:1]};
            end
            alu8_pkg::FUNC_DEC: r = it.operand - 8'd1;
            default: r = it.operand;
        endcase
        if (nz_from_r) begin
            o.result = r;
            o.negative = r[7];
            o.zero = r == 8'd0;
        end
        return o;
    endfunction

    function automatic alu8_pkg::t_alu_in random_item();
        alu8_pkg::t_alu_in it;
        it.func         = 4'($urandom_range(0, 15));
        it.acc          = 8'($urandom);
        it.operand      = 8'($urandom);
        it.carry_in     = 1'($urandom);
        it.overflow_in  = 1'($urandom);
        it.negative_in  = 1'($urandom);
        it.decimal_mode = 1'($urandom);
        if ($urandom_range(0, 7) == 0)
            it.acc = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        if ($urandom_range(0, 7) == 0)
            it.operand = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        // mostly well-formed BCD digits for decimal add
        if (it.func == alu8_pkg::FUNC_ADC && it.decimal_mode && $urandom_range(0, 3) != 0) begin
            it.acc     = {4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))};
            it.operand = {4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))};
        end
        return it;
    endfunction

    task automatic send_item(input alu8_pkg::t_alu_in it, input alu8_pkg::t_alu_out want);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do @(posedge i_clk); while (!o_in_ready);
        pending_results.push_back(want);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            error_count++;
        end
    endtask

    always @(posedge i_clk) begin : result_check
        alu8_pkg::t_alu_out want;
        if (i_rst_n && o_out_valid && out_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected item, expected none, actual %0h", $time, o_out_data);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("result",   want.result,   o_out_data.result);
                check_field("negative", want.negative, o_out_data.negative);
                check_field("overflow", want.overflow, o_out_data.overflow);
                check_field("zero",     want.zero,     o_out_data.zero);
                check_field("carry",    want.carry,    o_out_data.carry);
            end
        end
        out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin : stimulus
        int phase_idle [4] = '{0, 69, 0, 30};
        int phase_stall [4] = '{0, 0, 69, 30};
        alu8_pkg::t_alu_in it;
        i_rst_n <= 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[k]) begin
            send_item(directed_rows[k].stim,
                      directed_rows[k].typed ? directed_rows[k].want
                                             : predict_alu_result(directed_rows[k].stim));
        end
        drain_results();

        for (int p = 0; p < 4; p++) begin
            send_idle_pct  = phase_idle[p];
            recv_stall_pct = phase_stall[p];
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                it = random_item();
                send_item(it, predict_alu_result(it));
            end
            drain_results();
        end

        repeat (8) @(posedge i_clk);
        if (error_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
